@@ design/u8cd_pkg.sv @@
// Shared types, constants and decode functions for the UTF-8 code point decoder.
// Used by u8cd_ctrl, u8cd_datapath and utf8_codepoint_decoder; no dependencies.
package u8cd_pkg;

	localparam int unsigned CP_W = 21;
	localparam logic [CP_W-1:0] REPLACEMENT_CP = CP_W'(8'h3F);

	// Controller to datapath
	typedef struct packed {
		logic in_take;   // input word accepted this cycle
		logic rep_step;  // emit one replayed result
		logic rep_end;   // emit the end marker and clear held bytes
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic byte_zero; // input word is the terminator
		logic in_emits;  // a nonzero input word completes a result
		logic rep_more;  // held bytes remain to be replayed
	} status_t;

	// Sequence length from a lead byte, zero for an invalid lead
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] r;
		if ((b & 8'h80) == 8'h00) r = 3'd1;
		else if ((b & 8'hE0) == 8'hC0) r = 3'd2;
		else if ((b & 8'hF0) == 8'hE0) r = 3'd3;
		else if ((b & 8'hF8) == 8'hF0) r = 3'd4;
		else r = 3'd0;
		return r;
	endfunction

	// Join a complete sequence of the given length into a code point
	function automatic logic [CP_W-1:0] join_seq(input logic [7:0] s0, input logic [7:0] s1,
			input logic [7:0] s2, input logic [7:0] s3, input logic [2:0] len);
		logic [CP_W-1:0] r;
		case (len)
			3'd1: r = CP_W'(s0);
			3'd2: r = CP_W'({s0[4:0], s1[5:0]});
			3'd3: r = CP_W'({s0[3:0], s1[5:0], s2[5:0]});
			3'd4: r = {s0[2:0], s1[5:0], s2[5:0], s3[5:0]};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ design/u8cd_ctrl.sv @@
// Controller for the UTF-8 code point decoder: run/replay state machine and
// output handshake. Depends on u8cd_pkg.
module u8cd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  u8cd_pkg::status_t status,
	output u8cd_pkg::cmd_t    cmd
);

	typedef enum logic {
		ST_RUN,
		ST_REPLAY
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_load;

	assign can_load  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_RUN) && can_load;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.in_take  = in_valid && in_ready;
		cmd.rep_step = (state_q == ST_REPLAY) && can_load && status.rep_more;
		cmd.rep_end  = (state_q == ST_REPLAY) && can_load && !status.rep_more;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
		end else begin
			if (can_load) begin
				out_valid_q <= (cmd.in_take && status.in_emits) || cmd.rep_step || cmd.rep_end;
			end
			case (state_q)
				ST_RUN: begin
					// terminator: drain held bytes, then the end marker
					if (cmd.in_take && status.byte_zero) state_q <= ST_REPLAY;
				end
				ST_REPLAY: begin
					if (cmd.rep_end) state_q <= ST_RUN;
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

endmodule

@@ design/u8cd_datapath.sv @@
// Datapath for the UTF-8 code point decoder: held bytes, replay index and the
// output word register. Depends on u8cd_pkg.
module u8cd_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  in_byte,
	input  u8cd_pkg::cmd_t              cmd,
	output u8cd_pkg::status_t           status,
	output logic [u8cd_pkg::CP_W-1:0]   codepoint,
	output logic                        end_of_text,
	output logic                        last
);

	logic [7:0] held_q [3];
	logic [1:0] count_q;
	logic [1:0] idx_q;
	logic [u8cd_pkg::CP_W-1:0] cp_q;
	logic eot_q;
	logic last_q;

	// running path
	logic [2:0] in_len;
	logic [2:0] held_len;
	logic [7:0] s1;
	logic [7:0] s2;
	logic       complete;
	logic [u8cd_pkg::CP_W-1:0] run_cp;

	// replay path
	logic [7:0] r0, r1, r2, r3;
	logic [2:0] rep_len;
	logic [2:0] rep_adv;
	logic [u8cd_pkg::CP_W-1:0] rep_cp;
	logic [2:0] idx_next;

	always_comb begin
		in_len   = u8cd_pkg::lead_len(in_byte);
		held_len = u8cd_pkg::lead_len(held_q[0]);
		s1       = (count_q == 2'd1) ? in_byte : held_q[1];
		s2       = (count_q == 2'd2) ? in_byte : held_q[2];
		complete = ({1'b0, count_q} + 3'd1) >= held_len;
		run_cp   = '0;
		if (count_q == 2'd0) begin
			run_cp = (in_len == 3'd1) ? u8cd_pkg::CP_W'(in_byte) : u8cd_pkg::REPLACEMENT_CP;
		end else begin
			run_cp = u8cd_pkg::join_seq(held_q[0], s1, s2, in_byte, held_len);
		end

		status.byte_zero = (in_byte == 8'h00);
		status.in_emits  = (in_byte != 8'h00) &&
			((count_q == 2'd0) ? (in_len <= 3'd1) : complete);
		status.rep_more  = idx_q < count_q;
	end

	// replay window starting at the current index, zero padded
	always_comb begin
		case (idx_q)
			2'd0: begin r0 = held_q[0]; r1 = held_q[1]; r2 = held_q[2]; r3 = 8'h00; end
			2'd1: begin r0 = held_q[1]; r1 = held_q[2]; r2 = 8'h00; r3 = 8'h00; end
			2'd2: begin r0 = held_q[2]; r1 = 8'h00; r2 = 8'h00; r3 = 8'h00; end
			default: begin r0 = 8'h00; r1 = 8'h00; r2 = 8'h00; r3 = 8'h00; end
		endcase
		rep_len = u8cd_pkg::lead_len(r0);
		if (rep_len == 3'd1) begin
			rep_cp  = u8cd_pkg::CP_W'(r0);
			rep_adv = 3'd1;
		end else if (rep_len >= 3'd2 && ({1'b0, idx_q} + rep_len) <= {1'b0, count_q}) begin
			rep_cp  = u8cd_pkg::join_seq(r0, r1, r2, r3, rep_len);
			rep_adv = rep_len;
		end else begin
			rep_cp  = u8cd_pkg::REPLACEMENT_CP;
			rep_adv = 3'd1;
		end
		idx_next = {1'b0, idx_q} + rep_adv;
	end

	// control: held count and replay index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			idx_q   <= 2'd0;
		end else begin
			if (cmd.in_take) begin
				if (in_byte == 8'h00) begin
					idx_q <= 2'd0;
				end else if (count_q == 2'd0) begin
					if (in_len >= 3'd2) count_q <= 2'd1;
				end else if (complete) begin
					count_q <= 2'd0;
				end else begin
					count_q <= count_q + 2'd1;
				end
			end
			if (cmd.rep_step) idx_q <= idx_next[1:0];
			if (cmd.rep_end) count_q <= 2'd0;
		end
	end

	// payload: held bytes and output word
	always_ff @(posedge clk) begin
		if (cmd.in_take && in_byte != 8'h00) begin
			if (count_q == 2'd0) begin
				if (in_len >= 3'd2) held_q[0] <= in_byte;
			end else if (!complete) begin
				case (count_q)
					2'd1: held_q[1] <= in_byte;
					2'd2: held_q[2] <= in_byte;
					default: ;
				endcase
			end
		end
		if (cmd.in_take && status.in_emits) begin
			cp_q   <= run_cp;
			eot_q  <= 1'b0;
			last_q <= 1'b1;
		end else if (cmd.rep_step) begin
			cp_q   <= rep_cp;
			eot_q  <= 1'b0;
			last_q <= 1'b0;
		end else if (cmd.rep_end) begin
			cp_q   <= '0;
			eot_q  <= 1'b1;
			last_q <= 1'b1;
		end
	end

	assign codepoint   = cp_q;
	assign end_of_text = eot_q;
	assign last        = last_q;

endmodule

@@ design/utf8_codepoint_decoder.sv @@
// UTF-8 code point decoder: one byte word in, code point words out.
// A result is registered and appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle while the output is taken; a terminator
// holds the input while held bytes are replayed and the end marker is sent.
// Reset (arst_n low, asynchronous): nothing held, output empty.
// Depends on u8cd_pkg, u8cd_ctrl and u8cd_datapath.
module utf8_codepoint_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [20:0] codepoint, [23:21] zero
	output logic        m_tuser,  // [0] end_of_text
	output logic        m_tlast
);

	u8cd_pkg::cmd_t    cmd;
	u8cd_pkg::status_t status;
	logic [u8cd_pkg::CP_W-1:0] codepoint;

	u8cd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	u8cd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (s_tdata),
		.cmd         (cmd),
		.status      (status),
		.codepoint   (codepoint),
		.end_of_text (m_tuser),
		.last        (m_tlast)
	);

	assign m_tdata = {3'b000, codepoint};

endmodule
